// ===== rtl/twaf_pkg.sv =====
`timescale 1ns / 1ps
package twaf_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 24;

  // Signed width that holds the sum of WINDOW full-scale samples
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int DIVISOR = WINDOW - 2;

  // Reciprocal of DIVISOR scaled by 2^RECIP_K, truncated and then incremented by one
  localparam int RECIP_K = SUM_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_K) / DIVISOR) + 64'd1);
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int QD_W   = SUM_W + 1;

  localparam int CNT_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // Running sum, maximum and minimum handed from cell to cell
  typedef struct packed {
    sum_t    sum;
    sample_t hi;
    sample_t lo;
  } scan_tok_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Neutral token entering the first cell
  localparam scan_tok_t SEED_TOK = '{sum: '0, hi: SAMPLE_MIN, lo: SAMPLE_MAX};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/twaf_cell.sv =====
`timescale 1ns / 1ps
module twaf_cell (
  input  logic                clk,
  input  logic                shift_en,
  input  twaf_pkg::sample_t   sample_in,
  input  twaf_pkg::scan_tok_t tok_in,
  output twaf_pkg::sample_t   sample_out,
  output twaf_pkg::scan_tok_t tok_out
);
  import twaf_pkg::*;

  sample_t   sample_r;
  scan_tok_t tok_r;
  scan_tok_t tok_nxt;

  // fold own sample into the passing token
  always_comb begin
    tok_nxt.sum = tok_in.sum + SUM_W'(sample_r);
    tok_nxt.hi  = (sample_r > tok_in.hi) ? sample_r : tok_in.hi;
    tok_nxt.lo  = (sample_r < tok_in.lo) ? sample_r : tok_in.lo;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= sample_in;
    end
    tok_r <= tok_nxt;
  end

  assign sample_out = sample_r;
  assign tok_out    = tok_r;

endmodule

// ===== rtl/twaf_div.sv =====
`timescale 1ns / 1ps
module twaf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  twaf_pkg::sum_t    dividend,
  output logic              done,
  output twaf_pkg::sample_t quot
);
  import twaf_pkg::*;

  // stage 1: magnitude times reciprocal
  logic              v1_r;
  logic              neg1_r;
  logic [SUM_W-1:0]  mag1_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  mag_nxt;

  // stage 2: quotient estimate times divisor
  logic              v2_r;
  logic              neg2_r;
  logic [SUM_W-1:0]  mag2_r;
  logic [QD_W-1:0]   qest_r;
  logic [QD_W-1:0]   qd_r;
  logic [QD_W-1:0]   qest_nxt;

  // stage 3: one-step correction and sign
  logic              v3_r;
  sample_t           quot_r;
  logic [QD_W-1:0]   q_fix;
  sample_t           q_mag;

  assign mag_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign qest_nxt = QD_W'(prod_r >> RECIP_K);

  // estimate is exact or one too high
  assign q_fix = (qd_r > QD_W'(mag2_r)) ? (qest_r - QD_W'(1)) : qest_r;
  assign q_mag = SAMPLE_BITS'(q_fix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    neg1_r <= dividend[SUM_W-1];
    mag1_r <= mag_nxt;
    prod_r <= PROD_W'(mag_nxt) * PROD_W'(RECIP);
    neg2_r <= neg1_r;
    mag2_r <= mag1_r;
    qest_r <= qest_nxt;
    qd_r   <= QD_W'(qest_nxt * QD_W'(DIVISOR));
    quot_r <= neg2_r ? -q_mag : q_mag;
  end

  assign done = v3_r;
  assign quot = quot_r;

endmodule

// ===== rtl/trimmed_window_average_filter_core.sv =====
`timescale 1ns / 1ps
// Trimmed moving-average filter. Each input item is one signed sample (8
// fractional bits) and gives exactly one result item. The first WINDOW items
// after reset are passed through raw with is_filtered low; from then on the
// result is the sum of the last WINDOW samples minus their largest and
// smallest, divided by WINDOW-2 and truncated toward zero, with is_filtered
// high. The window lives in a row of WINDOW cells: a new sample shifts into
// the first cell and the oldest drops out of the last. A token carrying sum,
// max and min ripples one cell per cycle; a filtered item passes through the
// token ripple through the cell row and then a three-stage reciprocal-multiply
// divider before the next item can be taken. A finished result sits in the
// output register, and the next item is accepted while it waits to be taken.
module trimmed_window_average_filter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  twaf_pkg::sample_t in_sample_in,
  output logic              out_valid,
  input  logic              out_ready,
  output twaf_pkg::sample_t out_sample_out,
  output logic              out_is_filtered
);
  import twaf_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [FILL_W-1:0] fill_r;

  // pending result, handed to the output register in ST_DONE
  sample_t           res_r;
  logic              res_flt_r;

  logic              out_valid_r;
  sample_t           out_sample_r;
  logic              out_flt_r;

  logic              accept;
  logic              warm;
  logic              shift_en;
  logic              div_start;
  logic              out_load;

  sample_t           cell_smp [WINDOW+1];
  scan_tok_t         cell_tok [WINDOW+1];
  sum_t              trim_diff;
  logic              div_done;
  sample_t           div_quot;

  assign accept = in_valid && in_ready;
  assign warm   = (fill_r < FILL_W'(WINDOW));

  // ---------------- cell row ----------------
  assign cell_smp[0] = in_sample_in;
  assign cell_tok[0] = SEED_TOK;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    twaf_cell u_cell (
      .clk        (clk),
      .shift_en   (shift_en),
      .sample_in  (cell_smp[i]),
      .tok_in     (cell_tok[i]),
      .sample_out (cell_smp[i+1]),
      .tok_out    (cell_tok[i+1])
    );
  end

  // sum minus largest and smallest; always fits SUM_W
  assign trim_diff = cell_tok[WINDOW].sum - SUM_W'(cell_tok[WINDOW].hi)
                   - SUM_W'(cell_tok[WINDOW].lo);

  twaf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (trim_diff),
    .done     (div_done),
    .quot     (div_quot)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = warm ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // wait here until the token reaches the last cell
        if (cnt_r == CNT_W'(WINDOW - 1)) begin
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs of the FSM ----------------
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DONE:  out_load  = !out_valid_r || out_ready;
      default: begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  // warm-up stores too: order inside the window does not matter
  assign shift_en = accept;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && warm) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept && warm) begin
      res_r     <= in_sample_in;
      res_flt_r <= 1'b0;
    end else if (state_r == ST_WAIT && div_done) begin
      res_r     <= div_quot;
      res_flt_r <= 1'b1;
    end
    if (out_load) begin
      out_sample_r <= res_r;
      out_flt_r    <= res_flt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_is_filtered = out_flt_r;

  // ---------------- assertions ----------------
  // in_ready is low in the cycle after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // a filtered result only once the window has filled
  a_filtered_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flt_r) |-> (fill_r == FILL_W'(WINDOW)))
    else $error("filtered result before window full");

  // divider finishes only while the FSM waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_WAIT))
    else $error("divider result outside wait state");

  // a warm-up item goes straight to result delivery
  a_warm_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && warm) |=> (state_r == ST_DONE))
    else $error("warm-up item did not go to done");

endmodule
